// File: src/adf_pkg.sv
`timescale 1ns / 1ps

package adf_pkg;

  localparam int unsigned MAX_AD_LEN = 31;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // ad structure types and flag bits
  localparam logic [7:0] AD_FLAGS      = 8'h01;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] FLAG_LIMITED  = 8'h01;
  localparam logic [7:0] FLAG_GENERAL  = 8'h02;

  // register indexes
  localparam logic REG_DISC_MODE  = 1'b0;
  localparam logic REG_NAME_LIMIT = 1'b1;

  localparam logic [1:0] DISC_ALL     = 2'd0;
  localparam logic [1:0] DISC_LIMITED = 2'd1;
  localparam logic [1:0] DISC_GENERAL = 2'd2;

  localparam logic [4:0] NAME_LIMIT_RST = 5'd29;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    NM_NONE  = 2'd0,
    NM_EMIT  = 2'd1,
    NM_FOUND = 2'd2,
    NM_FAIL  = 2'd3
  } name_e;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] name_byte;
    logic       filter_pass;
    logic       name_found;
  } result_t;

endpackage

// File: src/adf_if.sv
`timescale 1ns / 1ps

// input channel: one advertising data byte per beat
interface adf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ad_byte;
  logic [4:0] report_len;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, ad_byte, report_len, first_byte, last_byte, input ready);
  modport sink   (input valid, ad_byte, report_len, first_byte, last_byte, output ready);
endinterface

// result channel: a name byte or a verdict per beat
interface adf_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] name_byte;
  logic       filter_pass;
  logic       name_found;

  modport source (output valid, result_kind, name_byte, filter_pass, name_found, input ready);
  modport sink   (input valid, result_kind, name_byte, filter_pass, name_found, output ready);
endinterface

// File: src/adv_data_filter_name_extract.sv
`timescale 1ns / 1ps
// results are registered in the result queue; the output shows the head of that queue
// throughput: one beat per cycle while in_if.ready is high; a beat's name byte and
//   verdict take two output beats, so the result queue (four entries) sets the pace
// reset: async active low; parse state cleared, disc_mode 0, name_limit 29,
//   result queue empty
module adv_data_filter_name_extract (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [4:0]      cfg_data_i,
  adf_in_if.sink          in_if,
  adf_out_if.source       out_if
);

  // configuration registers
  logic [1:0] disc_mode_q;
  logic [4:0] name_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_mode_q  <= adf_pkg::DISC_ALL;
      name_limit_q <= adf_pkg::NAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adf_pkg::REG_DISC_MODE:  disc_mode_q  <= cfg_data_i[1:0];
        adf_pkg::REG_NAME_LIMIT: name_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse state
  logic [adf_pkg::POS_W-1:0] byte_pos_q, byte_pos_d;
  logic [7:0]                field_left_q, field_left_d;
  logic [7:0]                field_type_q, field_type_d;
  adf_pkg::phase_e           phase_q, phase_d;
  logic                      flags_seen_q, flags_seen_d;
  logic [7:0]                flags_value_q, flags_value_d;
  adf_pkg::name_e            name_q, name_d;

  // result queue
  adf_pkg::result_t               fifo_q [adf_pkg::FIFO_DEPTH];
  logic [adf_pkg::PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [adf_pkg::CNT_W-1:0]      count_q;

  logic             in_fire, out_fire;
  logic             push_name, push_verdict;
  adf_pkg::result_t name_res, verdict_res;
  logic             pass;

  // room for two results is kept free so an accepted beat always has space for its results
  assign in_if.ready = (count_q <= adf_pkg::CNT_W'(adf_pkg::FIFO_DEPTH - 2));
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  // one byte of the walk
  always_comb begin
    logic [adf_pkg::POS_W-1:0] pos;
    logic [7:0]                left;
    logic [7:0]                ftype;
    adf_pkg::phase_e           ph;
    logic                      fseen;
    logic [7:0]                fval;
    adf_pkg::name_e            nm;
    logic [4:0]                eff;
    logic [8:0]                field_end;
    logic [7:0]                left_m1;

    // first_byte restarts the parse before its byte is used
    if (in_if.first_byte) begin
      pos   = '0;
      left  = '0;
      ftype = '0;
      ph    = adf_pkg::PH_LEN;
      fseen = 1'b0;
      fval  = '0;
      nm    = adf_pkg::NM_NONE;
    end else begin
      pos   = byte_pos_q;
      left  = field_left_q;
      ftype = field_type_q;
      ph    = phase_q;
      fseen = flags_seen_q;
      fval  = flags_value_q;
      nm    = name_q;
    end

    eff = (in_if.report_len < 5'(adf_pkg::MAX_AD_LEN)) ? in_if.report_len
                                                       : 5'(adf_pkg::MAX_AD_LEN);
    field_end = 9'(pos) + 9'd1 + 9'(in_if.ad_byte);
    left_m1   = left - 8'd1;
    push_name = 1'b0;

    // bytes past the report are ignored
    if (pos < eff && ph != adf_pkg::PH_STOP) begin
      unique case (ph)
        adf_pkg::PH_LEN: begin
          // zero length or overrun of the report ends the walk
          if (in_if.ad_byte == 8'd0 || field_end > 9'(eff)) begin
            ph = adf_pkg::PH_STOP;
          end else begin
            left = in_if.ad_byte;
            ph   = adf_pkg::PH_TYPE;
          end
        end
        adf_pkg::PH_TYPE: begin
          ftype = in_if.ad_byte;
          left  = left_m1;
          if (nm == adf_pkg::NM_NONE && (in_if.ad_byte == adf_pkg::AD_NAME_SHORT ||
                                         in_if.ad_byte == adf_pkg::AD_NAME_FULL)) begin
            if (left_m1 > 8'(name_limit_q)) nm = adf_pkg::NM_FAIL;
            else if (left_m1 == 8'd0)       nm = adf_pkg::NM_FOUND;  // empty name
            else                            nm = adf_pkg::NM_EMIT;
          end
          ph = (left_m1 != 8'd0) ? adf_pkg::PH_VALUE : adf_pkg::PH_LEN;
        end
        default: begin
          // value bytes
          if (ftype == adf_pkg::AD_FLAGS && !fseen) begin
            fval  = in_if.ad_byte;
            fseen = 1'b1;
          end
          push_name = (nm == adf_pkg::NM_EMIT);
          left = left_m1;
          if (left_m1 == 8'd0) begin
            if (nm == adf_pkg::NM_EMIT) nm = adf_pkg::NM_FOUND;
            ph = adf_pkg::PH_LEN;
          end
        end
      endcase
    end

    // saturating position
    if (pos != 5'(adf_pkg::MAX_AD_LEN)) pos = pos + 5'd1;

    // discovery filter over the flags as they stand after this byte
    unique case (disc_mode_q)
      adf_pkg::DISC_ALL:     pass = 1'b1;
      adf_pkg::DISC_LIMITED: pass = fseen && ((fval & adf_pkg::FLAG_LIMITED) != 8'd0);
      adf_pkg::DISC_GENERAL: pass = fseen &&
                               ((fval & (adf_pkg::FLAG_LIMITED | adf_pkg::FLAG_GENERAL)) != 8'd0);
      default:               pass = 1'b0;  // unknown mode never passes
    endcase

    push_verdict = in_if.last_byte;
    if (in_if.last_byte) ph = adf_pkg::PH_STOP;

    name_res.result_kind    = adf_pkg::KIND_NAME;
    name_res.name_byte      = in_if.ad_byte;
    name_res.filter_pass    = 1'b0;
    name_res.name_found     = 1'b0;
    verdict_res.result_kind = adf_pkg::KIND_VERDICT;
    verdict_res.name_byte   = 8'd0;
    verdict_res.filter_pass = pass;
    verdict_res.name_found  = (nm == adf_pkg::NM_FOUND);

    byte_pos_d    = pos;
    field_left_d  = left;
    field_type_d  = ftype;
    phase_d       = ph;
    flags_seen_d  = fseen;
    flags_value_d = fval;
    name_d        = nm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= '0;
      field_left_q  <= '0;
      field_type_q  <= '0;
      phase_q       <= adf_pkg::PH_LEN;
      flags_seen_q  <= 1'b0;
      flags_value_q <= '0;
      name_q        <= adf_pkg::NM_NONE;
    end else if (in_fire) begin
      byte_pos_q    <= byte_pos_d;
      field_left_q  <= field_left_d;
      field_type_q  <= field_type_d;
      phase_q       <= phase_d;
      flags_seen_q  <= flags_seen_d;
      flags_value_q <= flags_value_d;
      name_q        <= name_d;
    end
  end

  // queue writes: name byte first, verdict after it
  logic                      do_name, do_verdict;
  logic [adf_pkg::PTR_W-1:0] wr_ptr_p1;
  logic [1:0]                n_push;

  assign do_name    = in_fire && push_name;
  assign do_verdict = in_fire && push_verdict;
  assign wr_ptr_p1  = wr_ptr_q + adf_pkg::PTR_W'(1);
  assign n_push     = {1'b0, do_name} + {1'b0, do_verdict};

  always_ff @(posedge clk_i) begin
    if (do_name) fifo_q[wr_ptr_q] <= name_res;
    if (do_verdict) begin
      if (do_name) fifo_q[wr_ptr_p1] <= verdict_res;
      else         fifo_q[wr_ptr_q]  <= verdict_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + adf_pkg::PTR_W'(n_push);
      if (out_fire) rd_ptr_q <= rd_ptr_q + adf_pkg::PTR_W'(1);
      count_q  <= count_q + adf_pkg::CNT_W'(n_push) - adf_pkg::CNT_W'(out_fire);
    end
  end

  // output side reads the head of the queue
  assign out_if.valid       = (count_q != '0);
  assign out_if.result_kind = fifo_q[rd_ptr_q].result_kind;
  assign out_if.name_byte   = fifo_q[rd_ptr_q].name_byte;
  assign out_if.filter_pass = fifo_q[rd_ptr_q].filter_pass;
  assign out_if.name_found  = fifo_q[rd_ptr_q].name_found;

endmodule
